// ----- rtl/dps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_pkg
// Shared types and codes for the deadline priority scheduler.
// ----------------------------------------------------------------------------
package dps_pkg;

	localparam int DefCapacity = 16;
	localparam int PrioW = 8;
	localparam int TimeW = 16;
	localparam int StatW = 3;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_SERVE = 1'b1;

	typedef enum logic [StatW-1:0] {
		ST_ADDED   = 3'd0,
		ST_FULL    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_EXEC    = 3'd3,
		ST_EXPIRED = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_LAST  = 5'b00100,
		S_APPLY = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	function automatic logic [TimeW-1:0] sat_inc(input logic [TimeW-1:0] v);
		sat_inc = (v == {TimeW{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage

// ----- rtl/deadline_priority_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_priority_scheduler
// Bounded task store; add inserts, serve removes the best task by priority
// then age, with a deadline check and saturating tallies.
// ----------------------------------------------------------------------------
// One command is handled at a time. Task slots live in a synchronous memory
// with one read port; the occupancy bits are flip-flops, so an add needs no
// scan and its result is registered in the cycle after the transfer. A serve
// scans the memory one slot per cycle through SCAN, then passes through LAST
// and APPLY, where its result is registered. The result sits in an output
// register until transferred, and the state machine passes through OUT
// before the input opens again.
module deadline_priority_scheduler
	import dps_pkg::*;
#(
	parameter int CAPACITY = DefCapacity
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             command,
	input  logic [PrioW-1:0] task_priority,
	input  logic [TimeW-1:0] task_deadline,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [StatW-1:0] status,
	output logic [PrioW-1:0] served_priority,
	output logic [TimeW-1:0] served_deadline,
	output logic [TimeW-1:0] now_time,
	output logic [TimeW-1:0] count_total,
	output logic [TimeW-1:0] count_completed,
	output logic [TimeW-1:0] count_failed
);

	localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int EntW = PrioW + 2 * TimeW;

	state_t state_q;
	logic [CAPACITY-1:0] valid_q;
	logic [EntW-1:0] mem [CAPACITY];
	logic [EntW-1:0] rd_s1;
	logic [IdxW-1:0] rd_idx_s1, scan_q, best_idx_q;
	logic [PrioW-1:0] best_prio_q;
	logic [TimeW-1:0] best_age_q, best_dl_q;
	logic best_found_q, cmd_q, rd_en_s1;
	logic [TimeW-1:0] arrival_q, time_q, total_q, done_q, fail_q;

	logic [IdxW-1:0] free_idx;
	logic free_found;
	logic wr_en;
	logic [IdxW-1:0] rd_addr;
	logic rd_en;
	logic [PrioW-1:0] r_prio;
	logic [TimeW-1:0] r_dl, r_age;

	always_comb begin
		free_idx = '0;
		free_found = 1'b0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IdxW'(i);
				free_found = 1'b1;
			end
		end
	end

	assign in_stall = !(state_q == S_IDLE) || (out_valid && out_stall);
	assign rd_en = (state_q == S_SCAN);
	assign rd_addr = scan_q;
	assign wr_en = in_valid && !in_stall && (command == CMD_ADD) && free_found;

	always_ff @(posedge clk) begin
		if (wr_en) mem[free_idx] <= {task_priority, task_deadline, arrival_q};
		rd_s1 <= mem[rd_addr];
		rd_idx_s1 <= rd_addr;
	end

	assign r_prio = rd_s1[EntW-1 -: PrioW];
	assign r_dl = rd_s1[2*TimeW-1 -: TimeW];
	assign r_age = arrival_q - rd_s1[TimeW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			scan_q <= '0;
			best_found_q <= 1'b0;
			rd_en_s1 <= 1'b0;
			out_valid <= 1'b0;
			arrival_q <= '0;
			time_q <= '0;
			total_q <= '0;
			done_q <= '0;
			fail_q <= '0;
		end else begin
			rd_en_s1 <= rd_en;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			// scan compare on registered read data
			if (rd_en_s1 && valid_q[rd_idx_s1]) begin
				if (!best_found_q || r_prio > best_prio_q ||
				    (r_prio == best_prio_q && r_age > best_age_q)) begin
					best_found_q <= 1'b1;
					best_idx_q <= rd_idx_s1;
					best_prio_q <= r_prio;
					best_age_q <= r_age;
					best_dl_q <= r_dl;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						cmd_q <= command;
						scan_q <= '0;
						// for an add this flag holds whether a slot was free
						best_found_q <= (command == CMD_ADD) ? free_found : 1'b0;
						if (command == CMD_ADD) begin
							state_q <= S_APPLY;
							if (free_found) valid_q[free_idx] <= 1'b1;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_q == IdxW'(CAPACITY - 1)) state_q <= S_LAST;
					else scan_q <= scan_q + 1'b1;
				end
				S_LAST: state_q <= S_APPLY;
				S_APPLY: begin
					state_q <= S_OUT;
					out_valid <= 1'b1;
					if (cmd_q == CMD_ADD) begin
						served_priority <= '0;
						served_deadline <= '0;
						if (best_found_q) begin
							arrival_q <= arrival_q + 1'b1;
							total_q <= sat_inc(total_q);
							count_total <= sat_inc(total_q);
							status <= ST_ADDED;
						end else begin
							count_total <= total_q;
							status <= ST_FULL;
						end
						now_time <= time_q;
						count_completed <= done_q;
						count_failed <= fail_q;
					end else if (!best_found_q) begin
						served_priority <= '0;
						served_deadline <= '0;
						status <= ST_EMPTY;
						now_time <= time_q;
						count_total <= total_q;
						count_completed <= done_q;
						count_failed <= fail_q;
					end else begin
						valid_q[best_idx_q] <= 1'b0;
						served_priority <= best_prio_q;
						served_deadline <= best_dl_q;
						count_total <= total_q;
						if (time_q >= best_dl_q) begin
							status <= ST_EXPIRED;
							fail_q <= sat_inc(fail_q);
							count_failed <= sat_inc(fail_q);
							count_completed <= done_q;
							now_time <= time_q;
						end else begin
							status <= ST_EXEC;
							done_q <= sat_inc(done_q);
							count_completed <= sat_inc(done_q);
							time_q <= sat_inc(time_q);
							now_time <= sat_inc(time_q);
							count_failed <= fail_q;
						end
					end
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_only_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_APPLY))
		else $error("result without apply");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_add_sets_slot: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> valid_q[$past(free_idx)])
		else $error("added slot not marked");
	a_scan_one_hot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state not one-hot");

endmodule
